[sv/euler_to_quaternion_defines.svh]
// Assertion macros shared by etq_angle2rad, etq_cordic and euler_to_quaternion.
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ETQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/etq_pkg.sv]
package etq_pkg;

  localparam int ANG_W          = 16;
  localparam int OUT_W          = 16;
  localparam int OUT_FRAC_BITS  = 15;
  localparam int CORDIC_STAGES  = 16;
  localparam int LANES          = 3;

  localparam logic [16:0] TURN_UNITS    = 17'd46080;
  localparam logic [15:0] QUARTER_UNITS = 16'd11520;
  localparam logic [15:0] HALF_UNITS    = 16'd23040;
  localparam logic [15:0] THREEQ_UNITS  = 16'd34560;

  // HALF_PI_Q30 / QUARTER_UNITS split into quotient and remainder.
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam logic [17:0] RAD_Q  = 18'(HALF_PI_Q30 / 11520);
  localparam logic [13:0] RAD_R  = 14'(HALF_PI_Q30 % 11520);
  localparam int RECIP_SHIFT     = 41;
  localparam logic [27:0] RECIP  = 28'(((64'd1 << RECIP_SHIFT) + 64'd11519) / 64'd11520);

  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  typedef struct packed {
    logic [1:0]         quad;
    logic signed [31:0] theta;
  } etq_rad_t;

  typedef struct packed {
    logic signed [31:0] cosv;
    logic signed [31:0] sinv;
  } etq_sc_t;

  function automatic logic signed [31:0] atan_q30(input int idx);
    logic signed [31:0] v;
    case (idx)
      0: v = 32'sh3243F6A8;
      1: v = 32'sh1DAC6705;
      2: v = 32'sh0FADBAFC;
      3: v = 32'sh07F56EA6;
      4: v = 32'sh03FEAB76;
      5: v = 32'sh01FFD55B;
      6: v = 32'sh00FFFAAA;
      7: v = 32'sh007FFF55;
      8: v = 32'sh003FFFEA;
      9: v = 32'sh001FFFFD;
      10: v = 32'sh000FFFFF;
      11: v = 32'sh0007FFFF;
      12: v = 32'sh0003FFFF;
      13: v = 32'sh0001FFFF;
      14: v = 32'sh0000FFFF;
      15: v = 32'sh00007FFF;
      16: v = 32'sh00003FFF;
      17: v = 32'sh00001FFF;
      18: v = 32'sh00000FFF;
      19: v = 32'sh000007FF;
      20: v = 32'sh000003FF;
      21: v = 32'sh000001FF;
      22: v = 32'sh000000FF;
      23: v = 32'sh0000007F;
      24: v = 32'sh0000003F;
      25: v = 32'sh0000001F;
      26: v = 32'sh0000000F;
      27: v = 32'sh00000008;
      28: v = 32'sh00000004;
      29: v = 32'sh00000002;
      30: v = 32'sh00000001;
      default: v = 32'sh00000000;
    endcase
    return v;
  endfunction

  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [64:0] s);
    logic signed [64:0] r;
    logic signed [64:0] sh;
    logic signed [OUT_W-1:0] q;
    r  = s + (65'sd1 <<< (59 - OUT_FRAC_BITS));
    sh = r >>> (60 - OUT_FRAC_BITS);
    if (sh > 65'sd32767) begin
      q = 16'sh7FFF;
    end else if (sh < -65'sd32768) begin
      q = 16'sh8000;
    end else begin
      q = sh[OUT_W-1:0];
    end
    return q;
  endfunction

endpackage

[sv/etq_angle2rad.sv]
`include "euler_to_quaternion_defines.svh"

module etq_angle2rad
  import etq_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [ANG_W-1:0]     angle [LANES],
  output logic                        out_valid,
  input  logic                        out_ready,
  output etq_rad_t                    lane [LANES]
);

  logic [3:0] v;
  logic [3:0] rdy;

  logic [1:0]  q0 [LANES];
  logic [13:0] t0 [LANES];
  logic [1:0]  q1 [LANES];
  logic [31:0] p1 [LANES];
  logic [26:0] n1 [LANES];
  logic [1:0]  q2 [LANES];
  logic [31:0] p2 [LANES];
  logic [54:0] m2 [LANES];

  assign rdy[3] = !v[3] || out_ready;
  assign rdy[2] = !v[2] || rdy[3];
  assign rdy[1] = !v[1] || rdy[2];
  assign rdy[0] = !v[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [16:0] r17;
    logic [15:0] r;
    logic [1:0]  q;
    logic [15:0] base;

    always_comb begin
      r17 = {angle[l][ANG_W-1], angle[l]} + (angle[l][ANG_W-1] ? TURN_UNITS : 17'd0);
      r   = r17[15:0];
      if (r >= THREEQ_UNITS) begin
        q = 2'd3;
        base = THREEQ_UNITS;
      end else if (r >= HALF_UNITS) begin
        q = 2'd2;
        base = HALF_UNITS;
      end else if (r >= QUARTER_UNITS) begin
        q = 2'd1;
        base = QUARTER_UNITS;
      end else begin
        q = 2'd0;
        base = 16'd0;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[0]) begin
        q0[l] <= q;
        t0[l] <= 14'(r - base);
      end
      if (rdy[1]) begin
        q1[l] <= q0[l];
        p1[l] <= 32'({18'd0, t0[l]} * {14'd0, RAD_Q});
        n1[l] <= 27'({13'd0, t0[l]} * {13'd0, RAD_R} + 27'd5760);
      end
      if (rdy[2]) begin
        q2[l] <= q1[l];
        p2[l] <= p1[l];
        m2[l] <= {28'd0, n1[l]} * {27'd0, RECIP};
      end
      if (rdy[3]) begin
        lane[l].quad  <= q2[l];
        lane[l].theta <= $signed(p2[l] + 32'(m2[l] >> RECIP_SHIFT));
      end
    end
  end

  `ETQ_ASSERT_NOW(a_rem_range, v[0], (t0[0] < 14'd11520) && (t0[1] < 14'd11520) && (t0[2] < 14'd11520))

endmodule

[sv/etq_cordic.sv]
`include "euler_to_quaternion_defines.svh"

module etq_cordic
  import etq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  etq_rad_t lane [LANES],
  output logic     out_valid,
  input  logic     out_ready,
  output etq_sc_t  sc [LANES]
);

  localparam int LAST = CORDIC_STAGES - 1;

  logic signed [31:0] xr [CORDIC_STAGES][LANES];
  logic signed [31:0] yr [CORDIC_STAGES][LANES];
  logic signed [31:0] zr [CORDIC_STAGES][LANES];
  logic [1:0]         qr [CORDIC_STAGES][LANES];
  logic [CORDIC_STAGES-1:0] v;
  logic [CORDIC_STAGES-1:0] rdy;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    logic signed [31:0] xa [LANES];
    logic signed [31:0] ya [LANES];
    logic signed [31:0] za [LANES];
    logic [1:0]         qa [LANES];
    logic               va;

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          xa[l] = CORDIC_GAIN_Q30;
          ya[l] = 32'sd0;
          za[l] = lane[l].theta;
          qa[l] = lane[l].quad;
        end
        va = in_valid;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          xa[l] = xr[k-1][l];
          ya[l] = yr[k-1][l];
          za[l] = zr[k-1][l];
          qa[l] = qr[k-1][l];
        end
        va = v[k-1];
      end
    end

    if (k == LAST) begin : g_rdy_last
      assign rdy[k] = !v[k] || out_ready;
    end else begin : g_rdy
      assign rdy[k] = !v[k] || rdy[k+1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= va;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        for (int l = 0; l < LANES; l++) begin
          qr[k][l] <= qa[l];
          if (!za[l][31]) begin
            xr[k][l] <= xa[l] - (ya[l] >>> k);
            yr[k][l] <= ya[l] + (xa[l] >>> k);
            zr[k][l] <= za[l] - atan_q30(k);
          end else begin
            xr[k][l] <= xa[l] + (ya[l] >>> k);
            yr[k][l] <= ya[l] - (xa[l] >>> k);
            zr[k][l] <= za[l] + atan_q30(k);
          end
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[LAST];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      case (qr[LAST][l])
        2'd0: begin
          sc[l].cosv = xr[LAST][l];
          sc[l].sinv = yr[LAST][l];
        end
        2'd1: begin
          sc[l].cosv = -yr[LAST][l];
          sc[l].sinv = xr[LAST][l];
        end
        2'd2: begin
          sc[l].cosv = -xr[LAST][l];
          sc[l].sinv = -yr[LAST][l];
        end
        default: begin
          sc[l].cosv = yr[LAST][l];
          sc[l].sinv = -xr[LAST][l];
        end
      endcase
    end
  end

  `ETQ_ASSERT_NEXT(a_stall_hold, v[LAST] && !out_ready, v[LAST] && $stable(xr[LAST][0]) && $stable(yr[LAST][0]))

endmodule

[sv/etq_quat.sv]
module etq_quat
  import etq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  etq_sc_t                 sc [LANES],
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] quat_w,
  output logic signed [OUT_W-1:0] quat_x,
  output logic signed [OUT_W-1:0] quat_y,
  output logic signed [OUT_W-1:0] quat_z
);

  logic [2:0] v;
  logic [2:0] rdy;

  logic signed [63:0] pp [4];
  logic signed [31:0] cc0;
  logic signed [31:0] sc0;
  logic signed [63:0] tm [8];
  logic signed [31:0] ab [4];

  assign rdy[2] = !v[2] || out_ready;
  assign rdy[1] = !v[1] || rdy[2];
  assign rdy[0] = !v[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = v[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ab[j] = 32'((pp[j] + (64'sd1 <<< 29)) >>> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pp[0] <= sc[1].cosv * sc[2].cosv;
      pp[1] <= sc[1].sinv * sc[2].sinv;
      pp[2] <= sc[1].cosv * sc[2].sinv;
      pp[3] <= sc[1].sinv * sc[2].cosv;
      cc0   <= sc[0].cosv;
      sc0   <= sc[0].sinv;
    end
    if (rdy[1]) begin
      tm[0] <= ab[0] * cc0;
      tm[1] <= ab[1] * sc0;
      tm[2] <= ab[2] * sc0;
      tm[3] <= ab[3] * cc0;
      tm[4] <= ab[0] * sc0;
      tm[5] <= ab[1] * cc0;
      tm[6] <= ab[2] * cc0;
      tm[7] <= ab[3] * sc0;
    end
    if (rdy[2]) begin
      quat_w <= round_sat(65'(tm[0]) - 65'(tm[1]));
      quat_x <= round_sat(65'(tm[2]) + 65'(tm[3]));
      quat_y <= round_sat(65'(tm[4]) + 65'(tm[5]));
      quat_z <= round_sat(65'(tm[6]) - 65'(tm[7]));
    end
  end

endmodule

[sv/euler_to_quaternion.sv]
// Throughput: one transaction per cycle; every stage holds its data while stalled.
// The rate is set by the fully pipelined CORDIC, one register stage per iteration.
// Reset: synchronous, active high; clears all valid bits, the data path is not reset.
`include "euler_to_quaternion_defines.svh"

module euler_to_quaternion
  import etq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: course_angle, roll_angle, pitch_angle.
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: quat_w, quat_x, quat_y, quat_z.
  output logic [63:0] m_axis_tdata
);

  logic signed [ANG_W-1:0] angle [LANES];
  etq_rad_t rad [LANES];
  etq_sc_t  sc [LANES];
  logic rad_valid;
  logic rad_ready;
  logic sc_valid;
  logic sc_ready;
  logic signed [OUT_W-1:0] quat_w;
  logic signed [OUT_W-1:0] quat_x;
  logic signed [OUT_W-1:0] quat_y;
  logic signed [OUT_W-1:0] quat_z;

  assign angle[0] = $signed(s_axis_tdata[15:0]);
  assign angle[1] = $signed(s_axis_tdata[31:16]);
  assign angle[2] = $signed(s_axis_tdata[47:32]);

  etq_angle2rad u_rad (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .angle     (angle),
    .out_valid (rad_valid),
    .out_ready (rad_ready),
    .lane      (rad)
  );

  etq_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rad_valid),
    .in_ready  (rad_ready),
    .lane      (rad),
    .out_valid (sc_valid),
    .out_ready (sc_ready),
    .sc        (sc)
  );

  etq_quat u_quat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sc_valid),
    .in_ready  (sc_ready),
    .sc        (sc),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z)
  );

  assign m_axis_tdata = {quat_z, quat_y, quat_x, quat_w};

  `ETQ_ASSERT_NOW(a_empty_ready, !m_axis_tvalid, s_axis_tready)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import etq_pkg::*;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic signed [15:0] w;
  } quat_t;

  localparam longint GAIN_Q30     = 64'sd652032874;
  localparam longint RAD_HALF_PI  = 64'sd1686629713;
  localparam longint ONE_TURN     = 64'sd46080;
  localparam longint ONE_QUARTER  = 64'sd11520;
  localparam int     DRAIN_CYCLES = 40;
  localparam longint CYCLE_LIMIT  = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  quat_t  quat_queue[$];
  int     error_count = 0;
  int     sent_count = 0;
  int     checked_count = 0;
  int     hold_request = 0;
  bit     gaps_enabled = 1'b1;
  longint cycle_count = 0;

  euler_to_quaternion DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void half_angle_sincos(input logic signed [15:0] ang,
                                            output longint c, output longint s);
    longint r, q, t, x, y, z, dx, dy;
    r = (ang < 0) ? longint'(ang) + ONE_TURN : longint'(ang);
    q = r / ONE_QUARTER;
    t = r - q * ONE_QUARTER;
    x = GAIN_Q30;
    y = 0;
    z = (t * RAD_HALF_PI + ONE_QUARTER / 2) / ONE_QUARTER;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(atan_q30(i));
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(atan_q30(i));
      end
    end
    case (q & 3)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint triple_product(input longint a, input longint b, input longint c);
    longint ab;
    ab = (a * b + (64'sd1 << 29)) >>> 30;
    return ab * c;
  endfunction

  function automatic logic signed [15:0] q60_to_out(input longint v);
    longint r;
    r = (v + (64'sd1 << (59 - OUT_FRAC_BITS))) >>> (60 - OUT_FRAC_BITS);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic quat_t predict_quaternion(input logic [47:0] angles);
    longint cc, sc, cr, sr, cp, sp;
    quat_t qt;
    half_angle_sincos(angles[15:0], cc, sc);
    half_angle_sincos(angles[31:16], cr, sr);
    half_angle_sincos(angles[47:32], cp, sp);
    qt.w = q60_to_out(triple_product(cr, cp, cc) - triple_product(sr, sp, sc));
    qt.x = q60_to_out(triple_product(cr, sp, sc) + triple_product(sr, cp, cc));
    qt.y = q60_to_out(triple_product(cr, cp, sc) + triple_product(sr, sp, cc));
    qt.z = q60_to_out(triple_product(cr, sp, cc) - triple_product(sr, cp, sc));
    return qt;
  endfunction

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch on %s at result %0d: got %0d, expected %0d", field, checked_count,
             $signed(got), $signed(want));
    error_count++;
  endtask

  task automatic send_angles(input logic [15:0] course, input logic [15:0] roll,
                             input logic [15:0] pitch);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pitch, roll, course};
    do @(posedge clk); while (!s_axis_tready);
    quat_queue.insert(quat_queue.size(), predict_quaternion({pitch, roll, course}));
    sent_count++;
    if (gaps_enabled && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] random_angle();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 46080)) - 23040);
  endfunction

  always @(posedge clk) begin
    quat_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (quat_queue.size() == 0) begin
        $display("result with no transaction pending");
        error_count++;
      end else begin
        want = quat_queue.pop_front();
        if (got.w !== want.w) report_mismatch("quat_w", got.w, want.w);
        if (got.x !== want.x) report_mismatch("quat_x", got.x, want.x);
        if (got.y !== want.y) report_mismatch("quat_y", got.y, want.y);
        if (got.z !== want.z) report_mismatch("quat_z", got.z, want.z);
      end
      checked_count++;
    end
  end

  always @(posedge clk) begin
    int hold_left, phase;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      phase = (phase + 1) % 64;
      if (phase < 24) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic test_directed();
    logic [15:0] corners[11];
    corners = '{16'd0, 16'd23040, -16'sd23040, 16'h7FFF, 16'h8000, 16'd11520, -16'sd11520,
                16'd5760, 16'd11519, 16'd34560, 16'd1};
    foreach (corners[i]) send_angles(corners[i], 16'd0, 16'd0);
    foreach (corners[i]) if (i % 2 == 1) send_angles(16'd0, corners[i], corners[i]);
    send_angles(16'd23040, 16'd23040, 16'd23040);
    send_angles(16'h8000, 16'h7FFF, 16'h8000);
    send_angles(16'd5760, 16'd5760, 16'd5760);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_angles(random_angle(), random_angle(), random_angle());
  endtask

  task automatic test_backpressure();
    gaps_enabled = 1'b0;
    hold_request = 300;
    test_random(120);
    gaps_enabled = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(600);
    test_backpressure();
    test_random(600);
    s_axis_tvalid <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d angle triples and checked %0d quaternions,", sent_count, checked_count);
    $display("covering corner angles, random bursts and a long output stall.");
    if (error_count == 0 && quat_queue.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
